// ===== rtl/core/trm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiny register machine package
// Shared constants, opcode and phase types, and the per-beat result record.
// ----------------------------------------------------------------------------
package trm_pkg;

    // Size of the register file and the width of an index into it.
    localparam int unsigned NUM_REGS = 4;
    localparam int unsigned IDX_W    = $clog2(NUM_REGS);

    // Register count as a byte, for range checks on operand bytes.
    localparam logic [7:0] NUM_REGS_B = 8'(NUM_REGS);

    // Opcode bytes as they appear in the program stream.
    localparam logic [7:0] OP_HALT_B  = 8'h00;
    localparam logic [7:0] OP_LOAD_B  = 8'h01;
    localparam logic [7:0] OP_ADD_B   = 8'h02;
    localparam logic [7:0] OP_SUB_B   = 8'h03;
    localparam logic [7:0] OP_PRINT_B = 8'h04;

    // Opcode held while its operands are being collected.
    typedef enum logic [2:0] {
        OPC_HALT  = 3'd0,
        OPC_LOAD  = 3'd1,
        OPC_ADD   = 3'd2,
        OPC_SUB   = 3'd3,
        OPC_PRINT = 3'd4
    } opcode_t;

    // Decode phase: which byte of an instruction is expected next.
    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    // Everything reported for one program byte.
    typedef struct packed {
        logic [15:0] byte_address;
        logic        reg_written;
        logic [1:0]  written_index;
        logic [7:0]  written_value;
        logic        print_valid;
        logic [7:0]  print_value;
        logic        halted;
        logic        bad_register;
    } result_t;

endpackage

// ===== rtl/core/trm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiny register machine channels
// Valid/ready channels for program bytes in and per-byte results out.
// ----------------------------------------------------------------------------
interface trm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] instr_byte;

    modport source (output valid, output instr_byte, input ready);
    modport sink   (input valid, input instr_byte, output ready);
endinterface

interface trm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] byte_address;
    logic        reg_written;
    logic [1:0]  written_index;
    logic [7:0]  written_value;
    logic        print_valid;
    logic [7:0]  print_value;
    logic        halted;
    logic        bad_register;

    modport source (
        output valid, output byte_address, output reg_written, output written_index,
        output written_value, output print_valid, output print_value, output halted,
        output bad_register, input ready
    );
    modport sink (
        input valid, input byte_address, input reg_written, input written_index,
        input written_value, input print_valid, input print_value, input halted,
        input bad_register, output ready
    );
endinterface

// ===== rtl/core/trm_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiny register machine execute unit
// Decode state, register file and the single-pass byte execution logic.
// ----------------------------------------------------------------------------
module trm_exec (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          instr_byte,
    output trm_pkg::result_t    result
);

    trm_pkg::phase_t    phase_reg, phase_next;
    trm_pkg::opcode_t   pending_reg, pending_next;
    logic [7:0]         first_operand_reg, first_operand_next;
    logic [7:0]         dest_value_reg, dest_value_next;
    logic [15:0]        fetch_address_reg, fetch_address_next;
    logic               stopped_reg, stopped_next;
    logic [7:0]         reg_file_reg [trm_pkg::NUM_REGS];

    logic                       wr_en;
    logic [trm_pkg::IDX_W-1:0]  wr_idx;
    logic [7:0]                 wr_val;

    logic       has_operands;
    logic       src_ok;
    logic       dst_ok;
    logic [7:0] rd_val;

    // One read port, addressed by the incoming byte. The destination value is
    // captured when the first operand arrives, so the second operand only
    // needs this port for the source register.
    assign rd_val = reg_file_reg[instr_byte[trm_pkg::IDX_W-1:0]];
    assign src_ok = instr_byte < trm_pkg::NUM_REGS_B;
    assign dst_ok = first_operand_reg < trm_pkg::NUM_REGS_B;
    assign wr_idx = first_operand_reg[trm_pkg::IDX_W-1:0];

    always_comb
    begin
        unique case (instr_byte) inside
            trm_pkg::OP_LOAD_B, trm_pkg::OP_ADD_B, trm_pkg::OP_SUB_B, trm_pkg::OP_PRINT_B:
                has_operands = 1'b1;
            default:
                has_operands = 1'b0;
        endcase
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (!stopped_reg)
        begin
            unique case (phase_reg)
                trm_pkg::PH_FIRST:
                    phase_next = (pending_reg == trm_pkg::OPC_PRINT) ? trm_pkg::PH_OPCODE
                                                                      : trm_pkg::PH_SECOND;
                trm_pkg::PH_SECOND:
                    phase_next = trm_pkg::PH_OPCODE;
                default:
                    // Expecting an opcode; the unused phase code behaves the same.
                    phase_next = has_operands ? trm_pkg::PH_FIRST : trm_pkg::PH_OPCODE;
            endcase
        end
    end

    // Datapath and result for the current byte.
    always_comb
    begin
        result               = '0;
        result.byte_address  = fetch_address_reg;
        result.halted        = stopped_reg;
        wr_en                = 1'b0;
        wr_val               = instr_byte;
        stopped_next         = stopped_reg;
        pending_next         = pending_reg;
        first_operand_next   = first_operand_reg;
        dest_value_next      = dest_value_reg;
        fetch_address_next   = fetch_address_reg;

        if (!stopped_reg)
        begin
            fetch_address_next = fetch_address_reg + 16'd1;
            unique case (phase_reg)
                trm_pkg::PH_FIRST:
                begin
                    if (pending_reg == trm_pkg::OPC_PRINT)
                    begin
                        if (src_ok)
                        begin
                            result.print_valid = 1'b1;
                            result.print_value = rd_val;
                        end
                        else
                        begin
                            result.bad_register = 1'b1;
                        end
                    end
                    else
                    begin
                        first_operand_next = instr_byte;
                        dest_value_next    = rd_val;
                    end
                end
                trm_pkg::PH_SECOND:
                begin
                    if (pending_reg == trm_pkg::OPC_LOAD)
                    begin
                        wr_en  = dst_ok;
                        wr_val = instr_byte;
                    end
                    else
                    begin
                        wr_en  = dst_ok && src_ok;
                        wr_val = (pending_reg == trm_pkg::OPC_ADD) ? dest_value_reg + rd_val
                                                                    : dest_value_reg - rd_val;
                    end
                    result.reg_written   = wr_en;
                    result.bad_register  = !wr_en;
                    result.written_index = wr_en ? first_operand_reg[1:0] : 2'd0;
                    result.written_value = wr_en ? wr_val : 8'd0;
                end
                default:
                begin
                    if (instr_byte == trm_pkg::OP_HALT_B)
                    begin
                        stopped_next  = 1'b1;
                        result.halted = 1'b1;
                    end
                    else if (has_operands)
                    begin
                        pending_next = trm_pkg::opcode_t'(instr_byte[2:0]);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= trm_pkg::PH_OPCODE;
            pending_reg       <= trm_pkg::OPC_HALT;
            first_operand_reg <= 8'd0;
            dest_value_reg    <= 8'd0;
            fetch_address_reg <= 16'd0;
            stopped_reg       <= 1'b0;
            for (int i = 0; i < trm_pkg::NUM_REGS; i++)
            begin
                reg_file_reg[i] <= 8'd0;
            end
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            pending_reg       <= pending_next;
            first_operand_reg <= first_operand_next;
            dest_value_reg    <= dest_value_next;
            fetch_address_reg <= fetch_address_next;
            stopped_reg       <= stopped_next;
            if (wr_en)
            begin
                reg_file_reg[wr_idx] <= wr_val;
            end
        end
    end

    // Once halted, the core stays halted and its address stays frozen.
    assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("core left the halted state without reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> $stable(fetch_address_reg))
        else $error("fetch address moved while halted");

    // A running core advances its address by one for every accepted beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !stopped_reg) |=> fetch_address_reg == 16'($past(fetch_address_reg) + 16'd1))
        else $error("fetch address did not advance by one");

    // A byte completes at most one of write, print or bad-register report.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> $onehot0({result.reg_written, result.print_valid, result.bad_register}))
        else $error("conflicting completion flags on one byte");

endmodule

// ===== rtl/core/trm_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiny register machine output stage
// Result register that holds one beat while the receiver stalls.
// ----------------------------------------------------------------------------
module trm_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  trm_pkg::result_t    result,
    output logic                can_accept,
    trm_out_if.source           rsp
);

    logic               valid_reg, valid_next;
    trm_pkg::result_t   data_reg;

    // The register frees up in the same cycle its beat is taken.
    assign can_accept = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.byte_address  = data_reg.byte_address;
    assign rsp.reg_written   = data_reg.reg_written;
    assign rsp.written_index = data_reg.written_index;
    assign rsp.written_value = data_reg.written_value;
    assign rsp.print_valid   = data_reg.print_valid;
    assign rsp.print_value   = data_reg.print_value;
    assign rsp.halted        = data_reg.halted;
    assign rsp.bad_register  = data_reg.bad_register;

    // A loaded beat is presented in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

    // A pending beat is only replaced when the receiver has taken it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !rsp.ready) |-> !load)
        else $error("pending result overwritten");

    // A stalled beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !rsp.ready) |=> $stable(data_reg))
        else $error("stalled result changed");

endmodule

// ===== rtl/core/tiny_register_machine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiny register machine core
// Executes a byte-serial program stream and reports one result per byte.
// ----------------------------------------------------------------------------
// The instr channel carries the program one byte per beat, in fetch order
// from address zero. Every accepted byte produces exactly one beat on the
// result channel: the address the byte occupied, any register write it
// completed, any print it completed, the halted flag and an out-of-range
// register flag.
// Each byte is decoded and executed in the cycle it is accepted, against the
// decode state and the register file; the result lands in an output register
// and appears on the result channel in the cycle after acceptance. With the
// receiver ready, throughput is one byte per cycle. The result register is
// the only buffer: instr.ready is high whenever it is empty or being drained
// in the same cycle, so a stalled receiver holds back new bytes after one
// beat. Reset clears the decode phase, the pending opcode, all registers,
// the byte address and the halted flag. After a halt byte the core only
// reports the frozen address with halted set, until the next reset.
// ----------------------------------------------------------------------------
module tiny_register_machine_core (
    input  logic        clk,
    input  logic        rst_n,
    trm_in_if.sink      instr,
    trm_out_if.source   result
);

    // Decoded result of the byte currently on the input channel.
    trm_pkg::result_t   exec_result;

    // The output stage can take a new beat this cycle.
    logic               can_accept;

    // A program byte is consumed on this edge.
    logic               accept;

    assign instr.ready = can_accept;
    assign accept      = instr.valid && can_accept;

    // Decode state, register file and per-byte execution.
    trm_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .instr_byte (instr.instr_byte),
        .result     (exec_result)
    );

    // Result register toward the receiver.
    trm_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result     (exec_result),
        .can_accept (can_accept),
        .rsp        (result)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiny register machine core testbench
// Sends byte programs into the core over the instr channel and checks every
// result beat against hand-typed rows or a cycle-free model of decoder and registers.
// ----------------------------------------------------------------------------
// The run opens with a short directed program whose outcome is easy to read
// by eye: reset values, 8-bit wrap on add and subtract, prints, out-of-range
// register operands and unknown opcodes. Random programs follow, built from
// whole instructions so the decoder always returns to the opcode phase, first
// with the sender idling less than the receiver, then the other way round,
// then with no idling at all. The program ends with a halt and a few
// trailing bytes, since a halt holds until reset and reset happens only once.
// ----------------------------------------------------------------------------
module testbench;

    import trm_pkg::*;

    // One row of the directed program. Rows with has_typed set carry the
    // result beat written out by hand; the others use the decode model.
    typedef struct packed {
        logic [7:0] prog_byte;
        logic       has_typed;
        logic       wr;
        logic [1:0] idx;
        logic [7:0] val;
        logic       pv;
        logic [7:0] pval;
        logic       bad;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 27;

    // Program starts at address zero, so the address of each row is its index.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_LOAD_B,  1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0}, // right after reset
        '{8'h00,      1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'hFF,      1'b1, 1'b1, 2'd0, 8'hFF, 1'b0, 8'h00, 1'b0}, // r0 = 0xFF
        '{OP_LOAD_B,  1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h03,      1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h01,      1'b1, 1'b1, 2'd3, 8'h01, 1'b0, 8'h00, 1'b0}, // r3 = 1
        '{OP_ADD_B,   1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h00,      1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h03,      1'b1, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0}, // add wraps to 0
        '{OP_SUB_B,   1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h00,      1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h03,      1'b1, 1'b1, 2'd0, 8'hFF, 1'b0, 8'h00, 1'b0}, // sub wraps to 0xFF
        '{OP_PRINT_B, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h00,      1'b1, 1'b0, 2'd0, 8'h00, 1'b1, 8'hFF, 1'b0}, // print r0
        '{OP_PRINT_B, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{NUM_REGS_B, 1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b1}, // first bad index
        '{OP_LOAD_B,  1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'hFF,      1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h55,      1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b1}, // load, bad dest
        '{OP_ADD_B,   1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h01,      1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h80,      1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b1}, // add, bad source
        '{8'h05,      1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0}, // unknown opcodes
        '{8'hFF,      1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_SUB_B,   1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{NUM_REGS_B, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h00,      1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b1}  // sub, bad dest
    };

    logic clk;
    logic rst_n;

    trm_in_if  instr_bus ();
    trm_out_if result_bus ();

    tiny_register_machine_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_bus),
        .result (result_bus)
    );

    // Percent chance, per cycle, that the sender holds back a byte or the
    // receiver drops ready. The main sequence changes these between stretches.
    int unsigned sender_idle_pct = 29;
    int unsigned receiver_stall_pct = 52;

    int error_count = 0;
    int bytes_sent = 0;

    // Per byte handed to the sender, in order: whether a hand-written result
    // goes with it, and that result. Popped when the byte is accepted.
    bit      typed_flag_q [$];
    result_t typed_result_q [$];

    // Result beats still owed by the core, oldest first.
    result_t pending_results [$];

    // Decoder model state. It starts at its reset values and is never
    // cleared again, because reset is applied only once.
    phase_t     model_phase = PH_OPCODE;
    opcode_t    model_opcode = OPC_HALT;
    logic [7:0] model_dest = 8'h00;
    logic [7:0] model_regs [NUM_REGS] = '{default: 8'h00};
    logic [15:0] model_address = 16'h0000;
    bit         model_halted = 1'b0;

    // Runs one program byte through the decoder model and returns the result
    // beat the core should report for it.
    function automatic result_t execute_byte(input logic [7:0] b);
        result_t r;
        logic [7:0] sum;
        r = '0;
        r.byte_address = model_address;
        if (model_halted)
        begin
            // Frozen address, halted flag, nothing else.
            r.halted = 1'b1;
            return r;
        end
        model_address = model_address + 16'd1;
        case (model_phase)
            PH_FIRST:
            begin
                if (model_opcode == OPC_PRINT)
                begin
                    if (b < NUM_REGS_B)
                    begin
                        r.print_valid = 1'b1;
                        r.print_value = model_regs[b[IDX_W-1:0]];
                    end
                    else
                    begin
                        r.bad_register = 1'b1;
                    end
                    model_phase = PH_OPCODE;
                end
                else
                begin
                    model_dest = b;
                    model_phase = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                model_phase = PH_OPCODE;
                if (model_opcode == OPC_LOAD)
                begin
                    // A load checks only its destination.
                    if (model_dest < NUM_REGS_B)
                    begin
                        model_regs[model_dest[IDX_W-1:0]] = b;
                        r.reg_written = 1'b1;
                        r.written_index = 2'(model_dest);
                        r.written_value = b;
                    end
                    else
                    begin
                        r.bad_register = 1'b1;
                    end
                end
                else if (model_dest < NUM_REGS_B && b < NUM_REGS_B)
                begin
                    if (model_opcode == OPC_ADD)
                        sum = model_regs[model_dest[IDX_W-1:0]] + model_regs[b[IDX_W-1:0]];
                    else
                        sum = model_regs[model_dest[IDX_W-1:0]] - model_regs[b[IDX_W-1:0]];
                    model_regs[model_dest[IDX_W-1:0]] = sum;
                    r.reg_written = 1'b1;
                    r.written_index = 2'(model_dest);
                    r.written_value = sum;
                end
                else
                begin
                    r.bad_register = 1'b1;
                end
            end
            default:
            begin
                // Opcode phase. Unknown opcodes fall through as one-byte no-ops.
                model_phase = PH_OPCODE;
                if (b == OP_HALT_B)
                begin
                    model_halted = 1'b1;
                end
                else if (b == OP_LOAD_B || b == OP_ADD_B || b == OP_SUB_B
                         || b == OP_PRINT_B)
                begin
                    model_opcode = opcode_t'(b[2:0]);
                    model_phase = PH_FIRST;
                end
            end
        endcase
        r.halted = model_halted;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] expected_val,
                                        input logic [15:0] actual_val);
        if (actual_val !== expected_val)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expected_val, actual_val);
            error_count++;
        end
    endfunction

    // Free-running clock, 8 ns period.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: ready is redrawn on every edge, so stalls land on any phase
    // of the core's work, including while the single output register is full.
    initial
    begin
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watches both channels at each edge. Input beats feed the model first,
    // so an expectation is always queued before its result beat can show up.
    always @(posedge clk)
    begin
        result_t predicted;
        result_t typed_result;
        bit      use_typed;
        result_t want;
        if (rst_n === 1'b1)
        begin
            if (instr_bus.valid && instr_bus.ready)
            begin
                predicted = execute_byte(instr_bus.instr_byte);
                use_typed = typed_flag_q.pop_front();
                typed_result = typed_result_q.pop_front();
                pending_results.push_back(use_typed ? typed_result : predicted);
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat at address 0x%0h with no byte outstanding",
                           result_bus.byte_address);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("byte_address", want.byte_address, result_bus.byte_address);
                    check_field("reg_written", want.reg_written, result_bus.reg_written);
                    check_field("written_index", want.written_index, result_bus.written_index);
                    check_field("written_value", want.written_value, result_bus.written_value);
                    check_field("print_valid", want.print_valid, result_bus.print_valid);
                    check_field("print_value", want.print_value, result_bus.print_value);
                    check_field("halted", want.halted, result_bus.halted);
                    check_field("bad_register", want.bad_register, result_bus.bad_register);
                end
            end
        end
    end

    // Offers one byte, with random idle cycles in front, and returns at the
    // edge where it was taken. Valid stays high into the next byte unless
    // the next call decides to idle.
    task automatic send_byte(input logic [7:0] b, input bit has_typed,
                             input result_t typed_result);
        typed_flag_q.push_back(has_typed);
        typed_result_q.push_back(typed_result);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            instr_bus.valid <= 1'b0;
            @(posedge clk);
        end
        instr_bus.valid <= 1'b1;
        instr_bus.instr_byte <= b;
        do
            @(posedge clk);
        while (!instr_bus.ready);
        bytes_sent++;
    endtask

    // Register operand: mostly in range, sometimes anywhere above it.
    function automatic logic [7:0] random_register();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255, NUM_REGS));
        return 8'($urandom_range(NUM_REGS - 1));
    endfunction

    // One whole random instruction, never a halt. Sending whole instructions
    // keeps the decoder on an opcode boundary between calls.
    task automatic send_instruction();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 28)
        begin
            send_byte(OP_LOAD_B, 1'b0, '0);
            send_byte(random_register(), 1'b0, '0);
            send_byte(8'($urandom_range(255)), 1'b0, '0);
        end
        else if (pick < 68)
        begin
            send_byte((pick < 48) ? OP_ADD_B : OP_SUB_B, 1'b0, '0);
            send_byte(random_register(), 1'b0, '0);
            send_byte(random_register(), 1'b0, '0);
        end
        else if (pick < 88)
        begin
            send_byte(OP_PRINT_B, 1'b0, '0);
            send_byte(random_register(), 1'b0, '0);
        end
        else
        begin
            // Unknown opcode, a one-byte no-op.
            send_byte(8'($urandom_range(255, 5)), 1'b0, '0);
        end
    endtask

    // Main sequence.
    initial
    begin
        result_t typed_result;
        rst_n <= 1'b0;
        instr_bus.valid <= 1'b0;
        instr_bus.instr_byte <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed program, with the sender idling less than the receiver.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            typed_result = '0;
            typed_result.byte_address = 16'(bytes_sent);
            typed_result.reg_written = directed_rows[i].wr;
            typed_result.written_index = directed_rows[i].idx;
            typed_result.written_value = directed_rows[i].val;
            typed_result.print_valid = directed_rows[i].pv;
            typed_result.print_value = directed_rows[i].pval;
            typed_result.bad_register = directed_rows[i].bad;
            send_byte(directed_rows[i].prog_byte, directed_rows[i].has_typed, typed_result);
        end

        // Random programs under the three idling mixes.
        while (bytes_sent < 300)
            send_instruction();
        sender_idle_pct = 52;
        receiver_stall_pct = 29;
        while (bytes_sent < 570)
            send_instruction();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        while (bytes_sent < 835)
            send_instruction();

        // Halt, then bytes that must be ignored with the address frozen.
        send_byte(OP_HALT_B, 1'b0, '0);
        repeat (12)
            send_byte(8'($urandom_range(255)), 1'b0, '0);
        instr_bus.valid <= 1'b0;

        // Drain, then give the output register a few more cycles to show any
        // stray beat.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
